// ----- hdl/tscl_pkg.sv -----
// ----------------------------------------------------------------------------
// Two-sensor code lock package
// Shared types, register indexes, result codes and the digit pattern table.
// ----------------------------------------------------------------------------
package tscl_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE      = 2'd0,
		CFG_IDLE_TIMEOUT  = 2'd1,
		CFG_SECRET_FIRST  = 2'd2,
		CFG_SECRET_SECOND = 2'd3
	} cfg_idx_t;

	// Lock progress, one-hot.
	typedef enum logic [4:0] {
		ST_FIRST  = 5'b00001,
		ST_SECOND = 5'b00010,
		ST_CHECK  = 5'b00100,
		ST_ACCEPT = 5'b01000,
		ST_REJECT = 5'b10000
	} lock_state_t;

	// Phase codes as they appear on the result.
	localparam logic [2:0] PH_FIRST  = 3'd0;
	localparam logic [2:0] PH_SECOND = 3'd1;
	localparam logic [2:0] PH_CHECK  = 3'd2;
	localparam logic [2:0] PH_ACCEPT = 3'd3;
	localparam logic [2:0] PH_REJECT = 3'd4;

	typedef enum logic [1:0] {
		EV_NONE      = 2'd0,
		EV_ACCEPTED  = 2'd1,
		EV_REJECTED  = 2'd2,
		EV_EMERGENCY = 2'd3
	} event_t;

	// Seven-segment pattern of a decimal digit, bit 0 is segment A.
	function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
		logic [6:0] pat;
		case (digit)
			4'd0:    pat = 7'h3F;
			4'd1:    pat = 7'h06;
			4'd2:    pat = 7'h5B;
			4'd3:    pat = 7'h4F;
			4'd4:    pat = 7'h66;
			4'd5:    pat = 7'h6D;
			4'd6:    pat = 7'h7D;
			4'd7:    pat = 7'h07;
			4'd8:    pat = 7'h7F;
			4'd9:    pat = 7'h6F;
			default: pat = 7'h00;
		endcase
		return pat;
	endfunction

	function automatic logic [2:0] phase_code(input lock_state_t st);
		logic [2:0] code;
		unique case (st)
			ST_FIRST:  code = PH_FIRST;
			ST_SECOND: code = PH_SECOND;
			ST_CHECK:  code = PH_CHECK;
			ST_ACCEPT: code = PH_ACCEPT;
			ST_REJECT: code = PH_REJECT;
			default:   code = PH_FIRST;
		endcase
		return code;
	endfunction

endpackage

// ----- hdl/two_sensor_code_lock.sv -----
// ----------------------------------------------------------------------------
// Two-sensor code lock
// Counts debounced presses on two active-low sensors, checks them against a
// two-digit secret and reports the outcome, one result for every tick.
// ----------------------------------------------------------------------------
// Usage: every request on the input channel is one tick holding both sensor
// levels (0 means active) and an emergency flag. Every tick yields exactly one
// request on the output channel with the displayed segment pattern, the lock
// phase after the tick and an event code.
// A taken tick waits in the input register and is processed as it moves on
// into the result register, which then offers the result. Throughput: one
// tick per cycle unless the receiver stalls. The tick and result registers
// are separate, so a new tick is taken while an earlier result waits.
// Stalls: while the receiver stalls, the result register holds its request;
// one more tick is kept in the input register, and only then does in_stall
// rise. Nothing is lost or repeated.
// Reset: clears the lock state, counters and display and loads the register
// defaults (debounce 5, idle timeout 100, secret digits 2 and 3).
// Configuration writes take effect on the next edge; the user must make them
// while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module two_sensor_code_lock #(
	parameter int MAX_PRESSES = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tscl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tscl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           sensor_one_level,
	input  logic                           sensor_two_level,
	input  logic                           emergency_press,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [6:0]                     segments,
	output logic [2:0]                     phase,
	output logic [1:0]                     event_res
);
	import tscl_pkg::*;

	// The count must hold MAX_PRESSES itself.
	localparam int CW = $clog2(MAX_PRESSES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PRESSES);

	// Configuration registers.
	logic [7:0]  debounce_q;
	logic [15:0] timeout_q;
	logic [2:0]  secret_first_q;
	logic [2:0]  secret_second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q      <= 8'd5;
			timeout_q       <= 16'd100;
			secret_first_q  <= 3'd2;
			secret_second_q <= 3'd3;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEBOUNCE:      debounce_q      <= cfg_data[7:0];
				CFG_IDLE_TIMEOUT:  timeout_q       <= cfg_data;
				CFG_SECRET_FIRST:  secret_first_q  <= cfg_data[2:0];
				CFG_SECRET_SECOND: secret_second_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Input register: one tick waiting to be processed.
	logic valid_s1;
	logic one_level_s1;
	logic two_level_s1;
	logic emergency_s1;
	logic advance;

	// The tick moves on whenever the result register is empty or being drained.
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			one_level_s1 <= sensor_one_level;
			two_level_s1 <= sensor_two_level;
			emergency_s1 <= emergency_press;
		end
	end

	// Lock state.
	lock_state_t state_q;
	logic [CW-1:0] first_count_q;
	logic [CW-1:0] second_count_q;
	logic [15:0]   first_idle_q;
	logic [15:0]   second_idle_q;
	logic [7:0]    first_holdoff_q;
	logic [7:0]    second_holdoff_q;
	logic          first_was_q;
	logic          second_was_q;
	logic [6:0]    shown_q;

	// Next-state values for one tick.
	lock_state_t state_d;
	logic [CW-1:0] first_count_d;
	logic [CW-1:0] second_count_d;
	logic [15:0]   first_idle_d;
	logic [15:0]   second_idle_d;
	logic [7:0]    first_holdoff_d;
	logic [7:0]    second_holdoff_d;
	logic          first_was_d;
	logic          second_was_d;
	logic [6:0]    shown_d;
	event_t        event_d;
	logic          one_active;
	logic          two_active;
	logic          first_edge;
	logic          second_edge;
	logic          secret_match;
	logic          back_to_start;

	assign one_active = !one_level_s1;
	assign two_active = !two_level_s1;

	// A secret beyond the largest count can never match, hence the wide compare.
	assign secret_match = ({{(4 - CW){1'b0}}, first_count_q} == {1'b0, secret_first_q}) &&
		({{(4 - CW){1'b0}}, second_count_q} == {1'b0, secret_second_q});

	always_comb begin
		state_d          = state_q;
		first_count_d    = first_count_q;
		second_count_d   = second_count_q;
		first_idle_d     = first_idle_q;
		second_idle_d    = second_idle_q;
		first_holdoff_d  = first_holdoff_q;
		second_holdoff_d = second_holdoff_q;
		first_was_d      = first_was_q;
		second_was_d     = second_was_q;
		shown_d          = shown_q;
		event_d          = EV_NONE;
		first_edge       = 1'b0;
		second_edge      = 1'b0;
		back_to_start    = 1'b0;

		if (emergency_s1) begin
			event_d       = EV_EMERGENCY;
			back_to_start = 1'b1;
		end else begin
			if (first_holdoff_q != 8'd0) begin
				first_holdoff_d = first_holdoff_q - 8'd1;
			end
			if (second_holdoff_q != 8'd0) begin
				second_holdoff_d = second_holdoff_q - 8'd1;
			end

			// Sensor one is only watched while the first digit is entered.
			if (state_q == ST_FIRST) begin
				first_edge = one_active && !first_was_q && (first_holdoff_d == 8'd0);
				if (first_edge) begin
					if (first_count_q < CNT_MAX) begin
						first_count_d = first_count_q + CW'(1);
						shown_d       = seg_pattern(4'(first_count_d));
					end
					first_idle_d    = 16'd0;
					first_holdoff_d = debounce_q;
				end
				if (first_count_d != '0 && first_idle_d != 16'hFFFF) begin
					first_idle_d = first_idle_d + 16'd1;
				end
			end

			if (state_q == ST_SECOND) begin
				second_edge = two_active && !second_was_q && (second_holdoff_d == 8'd0);
				if (second_edge) begin
					if (second_count_q < CNT_MAX) begin
						second_count_d = second_count_q + CW'(1);
						shown_d        = seg_pattern(4'(second_count_d));
					end
					second_idle_d    = 16'd0;
					second_holdoff_d = debounce_q;
				end
				if (second_count_d != '0 && second_idle_d != 16'hFFFF) begin
					second_idle_d = second_idle_d + 16'd1;
				end
			end

			first_was_d  = one_active;
			second_was_d = two_active;

			unique case (state_q)
				ST_FIRST: begin
					if (first_count_d != '0 && first_idle_d >= timeout_q) begin
						state_d       = ST_SECOND;
						second_idle_d = 16'd0;
					end
				end
				ST_SECOND: begin
					if (second_count_d != '0 && second_idle_d >= timeout_q) begin
						state_d = ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_d = secret_match ? ST_ACCEPT : ST_REJECT;
				end
				ST_ACCEPT: begin
					event_d       = EV_ACCEPTED;
					back_to_start = 1'b1;
				end
				ST_REJECT: begin
					event_d       = EV_REJECTED;
					back_to_start = 1'b1;
				end
				default: begin
					back_to_start = 1'b1;
				end
			endcase
		end

		if (back_to_start) begin
			state_d          = ST_FIRST;
			first_count_d    = '0;
			second_count_d   = '0;
			first_idle_d     = 16'd0;
			second_idle_d    = 16'd0;
			first_holdoff_d  = 8'd0;
			second_holdoff_d = 8'd0;
			first_was_d      = 1'b0;
			second_was_d     = 1'b0;
			shown_d          = 7'd0;
		end
	end

	// State advances once per processed tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_FIRST;
			first_count_q    <= '0;
			second_count_q   <= '0;
			first_idle_q     <= 16'd0;
			second_idle_q    <= 16'd0;
			first_holdoff_q  <= 8'd0;
			second_holdoff_q <= 8'd0;
			first_was_q      <= 1'b0;
			second_was_q     <= 1'b0;
			shown_q          <= 7'd0;
		end else if (advance) begin
			state_q          <= state_d;
			first_count_q    <= first_count_d;
			second_count_q   <= second_count_d;
			first_idle_q     <= first_idle_d;
			second_idle_q    <= second_idle_d;
			first_holdoff_q  <= first_holdoff_d;
			second_holdoff_q <= second_holdoff_d;
			first_was_q      <= first_was_d;
			second_was_q     <= second_was_d;
			shown_q          <= shown_d;
		end
	end

	// Result register: holds its request until the receiver takes it.
	logic       out_valid_q;
	logic [6:0] segments_q;
	logic [2:0] phase_q;
	logic [1:0] event_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			segments_q <= shown_d;
			phase_q    <= phase_code(state_d);
			event_q    <= event_d;
		end
	end

	assign out_valid = out_valid_q;
	assign segments  = segments_q;
	assign phase     = phase_q;
	assign event_res = event_q;

	// Every reported event leaves the lock back at the start with a blank display.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && event_q != EV_NONE |-> phase_q == PH_FIRST && segments_q == 7'd0)
		else $error("event reported without return to start");

	// Counts never pass their saturation limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		first_count_q <= CNT_MAX && second_count_q <= CNT_MAX)
		else $error("press count beyond limit");

	// A tick is only held back while a result is waiting on a stalled receiver.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without output backpressure");

	// A tick in the check phase, with no emergency, resolves to accept or reject.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q == ST_CHECK && !emergency_s1
		|=> state_q == ST_ACCEPT || state_q == ST_REJECT)
		else $error("check phase did not resolve");

endmodule
